// File: rtl/phase_vocoder_bin_frequency_top_assert.svh
// Assertion macros for the phase vocoder bin frequency block.
// Used by the port checker; needs nothing else.
`ifndef PHASE_VOCODER_BIN_FREQUENCY_TOP_ASSERT_SVH
`define PHASE_VOCODER_BIN_FREQUENCY_TOP_ASSERT_SVH

// same-cycle implication
`define PVBF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvbf assertion failed");

// next-cycle implication
`define PVBF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvbf assertion failed");

`endif

// File: rtl/pvbf_pkg.sv
// Package for the phase vocoder bin frequency block.
// Types, register codes and reset values; no dependencies.
package pvbf_pkg;

   localparam int BIN_COUNT_DEFAULT = 1024;
   localparam int BIN_W             = 10;
   localparam int PHASE_W           = 16;
   localparam int FREQ_W            = 32;
   localparam int TDATA_W           = 64;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 32;

   localparam logic [15:0] HOP_ADVANCE_RESET   = 16'd16384;
   localparam logic [31:0] ANGLE_TO_FREQ_RESET = 32'd6000;
   localparam logic [31:0] BIN_SPACING_RESET   = 32'd1500;
   localparam logic [31:0] FREQ_TO_ANGLE_RESET = 32'd183251938;

   typedef enum logic {
      OP_ANALYSIS  = 1'b0,
      OP_SYNTHESIS = 1'b1
   } pvbf_op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HOP_ADVANCE   = 2'd0,
      CSR_ANGLE_TO_FREQ = 2'd1,
      CSR_BIN_SPACING   = 2'd2,
      CSR_FREQ_TO_ANGLE = 2'd3
   } pvbf_csr_index_type;

   typedef struct packed {
      logic [15:0] hop_advance_angle;
      logic [31:0] angle_to_freq_gain;
      logic [31:0] bin_spacing_freq;
      logic [31:0] freq_to_angle_gain;
   } pvbf_cfg_type;

   typedef struct packed {
      logic load;
      logic write;
   } pvbf_store_ctl_type;

endpackage

// File: rtl/pvbf_csr.sv
// Configuration registers of the phase vocoder bin frequency block.
// Depends on pvbf_pkg.
module pvbf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pvbf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pvbf_pkg::CSR_DATA_W-1:0]     csr_data,
   output pvbf_pkg::pvbf_cfg_type              cfg
);

   pvbf_pkg::pvbf_cfg_type cfg_ff;
   pvbf_pkg::pvbf_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (pvbf_pkg::pvbf_csr_index_type'(csr_index))
            pvbf_pkg::CSR_HOP_ADVANCE:   cfg_in.hop_advance_angle  = csr_data[15:0];
            pvbf_pkg::CSR_ANGLE_TO_FREQ: cfg_in.angle_to_freq_gain = csr_data;
            pvbf_pkg::CSR_BIN_SPACING:   cfg_in.bin_spacing_freq   = csr_data;
            pvbf_pkg::CSR_FREQ_TO_ANGLE: cfg_in.freq_to_angle_gain = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hop_advance_angle  <= pvbf_pkg::HOP_ADVANCE_RESET;
         cfg_ff.angle_to_freq_gain <= pvbf_pkg::ANGLE_TO_FREQ_RESET;
         cfg_ff.bin_spacing_freq   <= pvbf_pkg::BIN_SPACING_RESET;
         cfg_ff.freq_to_angle_gain <= pvbf_pkg::FREQ_TO_ANGLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/pvbf_phase_store.sv
// Per-bin phase store: one read, one write port, registered read with bypass
// of the write made in the same cycle, and a zeroing sweep after reset. Uses pvbf_pkg.
module pvbf_phase_store #(
   parameter int BIN_COUNT = pvbf_pkg::BIN_COUNT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pvbf_pkg::pvbf_store_ctl_type       ctl,
   input  logic [$clog2(BIN_COUNT)-1:0]       rd_addr,
   input  logic [$clog2(BIN_COUNT)-1:0]       wr_addr,
   input  logic [pvbf_pkg::PHASE_W-1:0]       wr_data,
   output logic [pvbf_pkg::PHASE_W-1:0]       rd_data,
   output logic                               busy
);

   localparam int AW = $clog2(BIN_COUNT);

   logic [pvbf_pkg::PHASE_W-1:0] mem [BIN_COUNT];

   logic [pvbf_pkg::PHASE_W-1:0] q_ff;
   logic [pvbf_pkg::PHASE_W-1:0] fwd_data_ff;
   logic                         fwd_hit_ff;
   logic                         clear_ff;
   logic                         clear_in;
   logic [AW-1:0]                clear_cnt_ff;
   logic [AW-1:0]                clear_cnt_in;
   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic [pvbf_pkg::PHASE_W-1:0] mem_wdata;

   assign busy    = clear_ff;
   assign rd_data = fwd_hit_ff ? fwd_data_ff : q_ff;

   assign mem_we    = clear_ff || ctl.write;
   assign mem_waddr = clear_ff ? clear_cnt_ff : wr_addr;
   assign mem_wdata = clear_ff ? '0 : wr_data;

   always_comb begin
      clear_in     = clear_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clear_ff) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == AW'(BIN_COUNT - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
      end else begin
         clear_ff     <= clear_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   // read happens when a new item enters the stage; a write retiring at the
   // same edge is caught by the bypass
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         q_ff        <= mem[rd_addr];
         fwd_hit_ff  <= ctl.write && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

endmodule

// File: rtl/phase_vocoder_bin_frequency_top.sv
// Phase vocoder bin frequency conversion, one spectral bin per transfer.
// Throughput is one item per cycle while rsp_tready is high and neither store is busy,
// set by the five-stage pipeline with at most one multiplier level per stage.
// Reset: registers return to their defaults, then both phase stores are swept
// to zero with req_tready low; csr writes are taken.
module phase_vocoder_bin_frequency_top #(
   parameter int BIN_COUNT = pvbf_pkg::BIN_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // bin_index[9:0], phase_in[25:10], freq_in[57:26], zero[63:58]
   input  logic [pvbf_pkg::TDATA_W-1:0]        req_tdata,
   // op[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // bin_out[9:0], freq_out[41:10], phase_out[57:42], zero[63:58]
   output logic [pvbf_pkg::TDATA_W-1:0]        rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pvbf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pvbf_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int AW = $clog2(BIN_COUNT);

   pvbf_pkg::pvbf_cfg_type       cfg;
   pvbf_pkg::pvbf_store_ctl_type ana_ctl;
   pvbf_pkg::pvbf_store_ctl_type syn_ctl;
   logic                         ana_busy;
   logic                         syn_busy;
   logic [15:0]                  ana_rd_data;
   logic [15:0]                  syn_rd_data;

   // input unpack
   pvbf_pkg::pvbf_op_type req_op;
   logic [9:0]            req_bin;
   logic [15:0]           req_phase;
   logic [31:0]           req_freq;
   logic [AW+9:0]         req_addr_ext;
   logic [AW-1:0]         req_addr;
   logic                  req_in_store;
   logic                  req_xfer;

   assign req_op       = pvbf_pkg::pvbf_op_type'(req_tuser);
   assign req_bin      = req_tdata[9:0];
   assign req_phase    = req_tdata[25:10];
   assign req_freq     = req_tdata[57:26];
   assign req_addr_ext = {{AW{1'b0}}, req_bin};
   assign req_addr     = req_addr_ext[AW-1:0];
   assign req_in_store = {22'd0, req_bin} < 32'(BIN_COUNT);

   // stage handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

   assign s5_rdy     = !s5_valid_ff || rsp_tready;
   assign s4_rdy     = !s4_valid_ff || s5_rdy;
   assign s3_rdy     = !s3_valid_ff || s4_rdy;
   assign s2_rdy     = !s2_valid_ff || s3_rdy;
   assign s1_rdy     = !s1_valid_ff || s2_rdy;
   assign req_tready = s1_rdy && !ana_busy && !syn_busy;
   assign req_xfer   = req_tvalid && req_tready;

   // stage 1: bin products
   pvbf_pkg::pvbf_op_type s1_op_ff;
   logic [9:0]            s1_bin_ff;
   logic [AW-1:0]         s1_addr_ff;
   logic                  s1_keep_ff;
   logic [15:0]           s1_phase_ff;
   logic [31:0]           s1_freq_ff;
   logic [25:0]           s1_bh_ff;
   logic [39:0]           s1_bs_ff;
   logic [25:0]           s1_bh_in;
   logic [41:0]           s1_bs_in;

   assign s1_bh_in = req_bin * cfg.hop_advance_angle;
   assign s1_bs_in = req_bin * cfg.bin_spacing_freq;

   // stage 2: analysis store read, bin offset removed
   pvbf_pkg::pvbf_op_type s2_op_ff;
   logic [9:0]            s2_bin_ff;
   logic [AW-1:0]         s2_addr_ff;
   logic                  s2_keep_ff;
   logic [15:0]           s2_phase_ff;
   logic [25:0]           s2_bh_ff;
   logic [39:0]           s2_rem_ff;
   logic [39:0]           s2_rem_in;

   assign s2_rem_in = {{8{s1_freq_ff[31]}}, s1_freq_ff} - s1_bs_ff;

   // stage 3: wrapped phase step plus expected advance; increment products
   pvbf_pkg::pvbf_op_type s3_op_ff;
   logic [9:0]            s3_bin_ff;
   logic [AW-1:0]         s3_addr_ff;
   logic                  s3_keep_ff;
   logic [27:0]           s3_sum_ff;
   logic [39:0]           s3_pl_ff;
   logic [7:0]            s3_ph_ff;
   logic [15:0]           ana_prev;
   logic [15:0]           s3_delta;
   logic [27:0]           s3_sum_in;
   logic [63:0]           s3_pl_full;
   logic [15:0]           s3_ph_full;

   assign ana_prev   = s2_keep_ff ? ana_rd_data : 16'd0;
   assign s3_delta   = s2_phase_ff - ana_prev;
   assign s3_sum_in  = {{12{s3_delta[15]}}, s3_delta} + {2'd0, s2_bh_ff};
   assign s3_pl_full = s2_rem_ff[31:0] * cfg.freq_to_angle_gain;
   assign s3_ph_full = s2_rem_ff[39:32] * cfg.freq_to_angle_gain[7:0];

   assign ana_ctl.load  = s1_valid_ff && s2_rdy;
   assign ana_ctl.write = s2_valid_ff && s3_rdy && (s2_op_ff == pvbf_pkg::OP_ANALYSIS)
                          && s2_keep_ff;

   // stage 4: frequency product; phase increment rounded; synthesis store read
   pvbf_pkg::pvbf_op_type s4_op_ff;
   logic [9:0]            s4_bin_ff;
   logic [AW-1:0]         s4_addr_ff;
   logic                  s4_keep_ff;
   logic [59:0]           s4_prod_ff;
   logic [15:0]           s4_inc_ff;
   logic signed [60:0]    s4_prod_full;
   logic [39:0]           s4_p40;
   logic [39:0]           s4_p40_rnd;

   assign s4_prod_full = $signed(s3_sum_ff) * $signed({1'b0, cfg.angle_to_freq_gain});
   assign s4_p40       = s3_pl_ff + {s3_ph_ff, 32'd0};
   assign s4_p40_rnd   = s4_p40 + 40'h00_0080_0000;

   // stage 5: output register; rounding and saturation, phase accumulate
   logic [9:0]            s5_bin_ff;
   logic [31:0]           s5_freq_ff;
   logic [15:0]           s5_phase_ff;
   logic [59:0]           s5_rnd;
   logic [43:0]           s5_q;
   logic [31:0]           s5_sat;
   logic [15:0]           syn_prev;
   logic [15:0]           s5_acc;
   logic [31:0]           s5_freq_in;
   logic [15:0]           s5_phase_in;

   assign s5_rnd = s4_prod_ff + 60'd32768;
   assign s5_q   = s5_rnd[59:16];

   always_comb begin
      if (s5_q[43:31] == {13{s5_q[43]}}) begin
         s5_sat = s5_q[31:0];
      end else if (s5_q[43]) begin
         s5_sat = 32'h8000_0000;
      end else begin
         s5_sat = 32'h7FFF_FFFF;
      end
   end

   assign syn_prev    = s4_keep_ff ? syn_rd_data : 16'd0;
   assign s5_acc      = syn_prev + s4_inc_ff;
   assign s5_freq_in  = (s4_op_ff == pvbf_pkg::OP_ANALYSIS) ? s5_sat : 32'd0;
   assign s5_phase_in = (s4_op_ff == pvbf_pkg::OP_SYNTHESIS) ? s5_acc : 16'd0;

   assign syn_ctl.load  = s3_valid_ff && s4_rdy;
   assign syn_ctl.write = s4_valid_ff && s5_rdy && (s4_op_ff == pvbf_pkg::OP_SYNTHESIS)
                          && s4_keep_ff;

   assign rsp_tvalid = s5_valid_ff;
   assign rsp_tdata  = {6'd0, s5_phase_ff, s5_freq_ff, s5_bin_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_valid_ff <= req_xfer;
         end
         if (s2_rdy) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_rdy) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_rdy) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (s5_rdy) begin
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff    <= req_op;
         s1_bin_ff   <= req_bin;
         s1_addr_ff  <= req_addr;
         s1_keep_ff  <= req_in_store;
         s1_phase_ff <= req_phase;
         s1_freq_ff  <= req_freq;
         s1_bh_ff    <= s1_bh_in;
         s1_bs_ff    <= s1_bs_in[39:0];
      end
      if (s1_valid_ff && s2_rdy) begin
         s2_op_ff    <= s1_op_ff;
         s2_bin_ff   <= s1_bin_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_keep_ff  <= s1_keep_ff;
         s2_phase_ff <= s1_phase_ff;
         s2_bh_ff    <= s1_bh_ff;
         s2_rem_ff   <= s2_rem_in;
      end
      if (s2_valid_ff && s3_rdy) begin
         s3_op_ff   <= s2_op_ff;
         s3_bin_ff  <= s2_bin_ff;
         s3_addr_ff <= s2_addr_ff;
         s3_keep_ff <= s2_keep_ff;
         s3_sum_ff  <= s3_sum_in;
         s3_pl_ff   <= s3_pl_full[39:0];
         s3_ph_ff   <= s3_ph_full[7:0];
      end
      if (s3_valid_ff && s4_rdy) begin
         s4_op_ff   <= s3_op_ff;
         s4_bin_ff  <= s3_bin_ff;
         s4_addr_ff <= s3_addr_ff;
         s4_keep_ff <= s3_keep_ff;
         s4_prod_ff <= s4_prod_full[59:0];
         s4_inc_ff  <= s4_p40_rnd[39:24];
      end
      if (s4_valid_ff && s5_rdy) begin
         s5_bin_ff   <= s4_bin_ff;
         s5_freq_ff  <= s5_freq_in;
         s5_phase_ff <= s5_phase_in;
      end
   end

   pvbf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pvbf_phase_store #(
      .BIN_COUNT (BIN_COUNT)
   ) u_ana_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ana_ctl),
      .rd_addr (s1_addr_ff),
      .wr_addr (s2_addr_ff),
      .wr_data (s2_phase_ff),
      .rd_data (ana_rd_data),
      .busy    (ana_busy)
   );

   pvbf_phase_store #(
      .BIN_COUNT (BIN_COUNT)
   ) u_syn_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (syn_ctl),
      .rd_addr (s3_addr_ff),
      .wr_addr (s4_addr_ff),
      .wr_data (s5_acc),
      .rd_data (syn_rd_data),
      .busy    (syn_busy)
   );

endmodule

// File: rtl/pvbf_checker.sv
// Port checker for phase_vocoder_bin_frequency_top, bound to the top level.
// Depends on pvbf_pkg and phase_vocoder_bin_frequency_top_assert.svh.
`include "phase_vocoder_bin_frequency_top_assert.svh"

module pvbf_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [pvbf_pkg::TDATA_W-1:0]        rsp_tdata
);

   localparam logic [3:0] PIPE_DEPTH = 4'd5;

   logic [3:0] pending_ff;
   logic [3:0] pending_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `PVBF_ASSERT_NOW(a_no_orphan_rsp, clock, reset, rsp_tvalid, pending_ff != 4'd0)
   `PVBF_ASSERT_NOW(a_pending_bound, clock, reset, 1'b1, pending_ff <= PIPE_DEPTH)
   `PVBF_ASSERT_NEXT(a_sweep_after_reset, clock, 1'b0, reset, !req_tready)
   `PVBF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata))

endmodule

bind phase_vocoder_bin_frequency_top pvbf_checker u_pvbf_checker (.*);
